// File: hw/rtl/time_ordered_job_queue_defines.svh
// ----------------------------------------------------------------------------
// Time-ordered job queue: assertion macros
// Shared concurrent-check macros for the queue RTL.
// ----------------------------------------------------------------------------
`ifndef TIME_ORDERED_JOB_QUEUE_DEFINES_SVH
`define TIME_ORDERED_JOB_QUEUE_DEFINES_SVH

// Check that a condition implies another in the same cycle
`define TOJQ_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("queue check failed in same cycle");

// Check that a condition implies another in the next cycle
`define TOJQ_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("queue check failed one cycle later");

`endif

// File: hw/rtl/tojq_pkg.sv
// ----------------------------------------------------------------------------
// Time-ordered job queue package
// Operation and status codes, entry and cell command types.
// ----------------------------------------------------------------------------
package tojq_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned JOB_W  = 16;
  localparam int unsigned OCC_W  = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_CHECK  = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE  = 3'd0,
    ST_EMPTY = 3'd1,
    ST_FULL  = 3'd2,
    ST_READY = 3'd3,
    ST_WAIT  = 3'd4
  } status_t;

  // One queued job as held by a cell
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] start;
    logic [JOB_W-1:0]  job;
  } entry_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [TIME_W-1:0] key;
    logic [JOB_W-1:0]  job;
  } cmd_t;

endpackage

// File: hw/rtl/tojq_cell.sv
// ----------------------------------------------------------------------------
// Time-ordered job queue: sorting cell
// Holds one entry; on insert keeps, loads or shifts down; on remove shifts up.
// ----------------------------------------------------------------------------
module tojq_cell (
  input  logic            clk,
  input  logic            rst,
  input  tojq_pkg::cmd_t   cmd,
  input  tojq_pkg::entry_t left,       // neighbor closer to the head
  input  logic            left_keep,  // neighbor keeps its entry on insert
  input  tojq_pkg::entry_t right,      // neighbor farther from the head
  output tojq_pkg::entry_t cur,
  output logic            keep
);
  import tojq_pkg::*;

  logic              valid;
  logic [TIME_W-1:0] start;
  logic [JOB_W-1:0]  job;
  logic              valid_next;
  logic [TIME_W-1:0] start_next;
  logic [JOB_W-1:0]  job_next;

  assign cur  = '{valid: valid, start: start, job: job};
  // Equal start times stay ahead of the new job
  assign keep = valid && (start <= cmd.key);

  // Select next entry
  always_comb begin
    valid_next = valid;
    start_next = start;
    job_next   = job;
    priority if (cmd.ins) begin
      if (keep) begin
        valid_next = valid;
      end else if (left_keep) begin
        valid_next = 1'b1;
        start_next = cmd.key;
        job_next   = cmd.job;
      end else begin
        valid_next = left.valid;
        start_next = left.start;
        job_next   = left.job;
      end
    end else if (cmd.rem) begin
      valid_next = right.valid;
      start_next = right.start;
      job_next   = right.job;
    end else begin
      valid_next = valid;
    end
  end

  // Hold valid under reset
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    start <= start_next;
    job   <= job_next;
  end

endmodule

// File: hw/rtl/time_ordered_job_queue.sv
// Result: the result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one operation per cycle while results are taken; every cell
// compares its start time with the broadcast key in the same cycle, so the
// insert path is one 32-bit compare plus a three-way select per cell.
// Reset: clears the queue count, every cell's valid bit and the result valid.
// ----------------------------------------------------------------------------
// Time-ordered job queue
// Sorted priority queue of pending jobs built as a chain of compare cells.
// ----------------------------------------------------------------------------
`include "time_ordered_job_queue_defines.svh"

module time_ordered_job_queue #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // start_time[31:0], job_number[47:32], now_time[79:48]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // wait_seconds[31:0], head_job[47:32],
                                 // head_start[79:48], occupancy[84:80], zero pad
  output logic [2:0]  m_tuser    // status[2:0]
);
  import tojq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic              fire;
  op_t               op;
  logic [TIME_W-1:0] in_start;
  logic [JOB_W-1:0]  in_job;
  logic [TIME_W-1:0] in_now;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic              full;
  logic              empty;
  cmd_t              cmd;
  entry_t            cells [DEPTH];
  logic              keeps [DEPTH];
  logic [DEPTH-1:0]  valid_vec;
  entry_t            head;

  status_t           status;
  logic [TIME_W-1:0] wait_s;
  logic [JOB_W-1:0]  hjob;
  logic [TIME_W-1:0] hstart;

  status_t           r_status;
  logic [TIME_W-1:0] r_wait;
  logic [JOB_W-1:0]  r_job;
  logic [TIME_W-1:0] r_start;
  logic [OCC_W-1:0]  r_occ;

  // Unpack the input beat
  assign fire     = s_tvalid && s_tready;
  assign s_tready = !m_tvalid || m_tready;
  assign op       = op_t'(s_tuser);
  assign in_start = s_tdata[31:0];
  assign in_job   = s_tdata[47:32];
  assign in_now   = s_tdata[79:48];

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = cells[0];

  // Broadcast the command to the chain
  assign cmd = '{ins: fire && (op == OP_INSERT) && !full,
                 rem: fire && (op == OP_REMOVE) && !empty,
                 key: in_start,
                 job: in_job};

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t lft;
    entry_t rgt;
    logic   lkeep;
    if (i == 0) begin : g_first
      // Nothing sits ahead of the head, so it loads the new job when it yields
      assign lft   = '0;
      assign lkeep = 1'b1;
    end else begin : g_mid
      assign lft   = cells[i-1];
      assign lkeep = keeps[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign rgt = '0;
    end else begin : g_inner
      assign rgt = cells[i+1];
    end
    tojq_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .left      (lft),
      .left_keep (lkeep),
      .right     (rgt),
      .cur       (cells[i]),
      .keep      (keeps[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  // Track the count
  always_comb begin
    count_next = count;
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.rem) begin
      count_next = count - CW'(1);
    end
  end

  // Form the result
  always_comb begin
    status = ST_DONE;
    wait_s = '0;
    hjob   = '0;
    hstart = '0;
    unique case (op)
      OP_INSERT: begin
        status = full ? ST_FULL : ST_DONE;
      end
      OP_CHECK: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          hjob   = head.job;
          hstart = head.start;
          if (head.start <= in_now) begin
            status = ST_READY;
          end else begin
            status = ST_WAIT;
            wait_s = head.start - in_now;
          end
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          status = ST_EMPTY;
        end else begin
          hjob   = head.job;
          hstart = head.start;
        end
      end
      default: begin
        status = ST_DONE;
      end
    endcase
  end

  // Advance count and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (fire) begin
      r_status <= status;
      r_wait   <= wait_s;
      r_job    <= hjob;
      r_start  <= hstart;
      r_occ    <= OCC_W'(count_next);
    end
  end

  assign m_tuser = r_status;
  assign m_tdata = {3'b000, r_occ, r_start, r_job, r_wait};

  `TOJQ_ASSERT_SAME(a_count_max, clk, rst, 1'b1, count <= CW'(DEPTH))
  `TOJQ_ASSERT_SAME(a_head_valid, clk, rst, 1'b1, valid_vec[0] == (count != '0))
  `TOJQ_ASSERT_SAME(a_valid_packed, clk, rst, 1'b1, ((valid_vec >> 1) & ~valid_vec) == '0)
  `TOJQ_ASSERT_NEXT(a_insert_grows, clk, rst, cmd.ins, count == $past(count) + CW'(1))

endmodule

// File: verif/time_ordered_job_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time-ordered job queue checker
// Watches both stream channels and keeps its own sorted copy of the queued
// jobs. Each accepted operation beat yields one predicted result. Each
// accepted result beat is compared field by field with the oldest one.
// ----------------------------------------------------------------------------
module time_ordered_job_queue_checker #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [79:0] s_tdata,   // start_time[31:0], job_number[47:32], now_time[79:48]
  input  logic [1:0]  s_tuser,   // operation[1:0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [87:0] m_tdata,   // wait_seconds[31:0], head_job[47:32],
                                 // head_start[79:48], occupancy[84:80], zero pad
  input  logic [2:0]  m_tuser,   // status[2:0]
  output int          fail_count,
  output int          results_owed
);
  import tojq_pkg::*;

  typedef struct {
    status_t           status;
    logic [TIME_W-1:0] wait_secs;
    logic [JOB_W-1:0]  head_job;
    logic [TIME_W-1:0] head_start;
    logic [OCC_W-1:0]  occupancy;
  } job_result_t;

  // Sorted job list, head at index 0
  logic [TIME_W-1:0] sched_start [DEPTH];
  logic [JOB_W-1:0]  sched_job   [DEPTH];
  int unsigned       sched_count;

  job_result_t awaited_results [$];

  // Apply one operation to the job list and return the result it yields
  function automatic job_result_t apply_job_op(logic [1:0] op, logic [TIME_W-1:0] st,
                                               logic [JOB_W-1:0] jb, logic [TIME_W-1:0] nw);
    job_result_t r;
    int unsigned slot;
    r.status     = ST_DONE;
    r.wait_secs  = '0;
    r.head_job   = '0;
    r.head_start = '0;
    case (op)
      OP_INSERT: begin
        if (sched_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // new job goes after every job starting at or before it
          slot = 0;
          while (slot < sched_count && sched_start[slot] <= st) slot++;
          for (int unsigned i = sched_count; i > slot; i--) begin
            sched_start[i] = sched_start[i-1];
            sched_job[i]   = sched_job[i-1];
          end
          sched_start[slot] = st;
          sched_job[slot]   = jb;
          sched_count++;
        end
      end
      OP_CHECK: begin
        if (sched_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_job   = sched_job[0];
          r.head_start = sched_start[0];
          if (sched_start[0] <= nw) begin
            r.status = ST_READY;
          end else begin
            r.status    = ST_WAIT;
            r.wait_secs = sched_start[0] - nw;
          end
        end
      end
      OP_REMOVE: begin
        if (sched_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head_job   = sched_job[0];
          r.head_start = sched_start[0];
          for (int unsigned i = 0; i + 1 < sched_count; i++) begin
            sched_start[i] = sched_start[i+1];
            sched_job[i]   = sched_job[i+1];
          end
          sched_count--;
        end
      end
      default: ;  // unused code: no change, status done
    endcase
    r.occupancy = sched_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count++;
    end
  endfunction

  // Compare result beats first, then record the operation beat of this edge
  always @(posedge clk) begin : watch
    job_result_t want;
    if (rst) begin
      sched_count = 0;
      awaited_results.delete();
      fail_count = 0;
      results_owed <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result beat with no operation outstanding, status 0x%0h", m_tuser);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("status", 32'(want.status), 32'(m_tuser));
          check_field("wait_seconds", want.wait_secs, m_tdata[31:0]);
          check_field("head_job", 32'(want.head_job), 32'(m_tdata[47:32]));
          check_field("head_start", want.head_start, m_tdata[79:48]);
          check_field("occupancy", 32'(want.occupancy), 32'(m_tdata[84:80]));
          check_field("pad", 32'd0, 32'(m_tdata[87:85]));
        end
      end
      if (s_tvalid && s_tready) begin
        awaited_results.push_back(apply_job_op(s_tuser, s_tdata[31:0], s_tdata[47:32],
                                               s_tdata[79:48]));
      end
      results_owed <= awaited_results.size();
    end
  end

endmodule

// File: verif/tb_time_ordered_job_queue.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Time-ordered job queue testbench
// Drives insert, check, remove and unused operations in bursts, first a
// directed sweep of empty, full, tie and extreme-time cases, then random
// phases biased to fill or drain the queue. The receiver stalls on its own
// pattern, with long hold-offs that back the queue up into its input.
// ----------------------------------------------------------------------------
module tb_time_ordered_job_queue;
  import tojq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int CLK_PERIOD     = 4;
  localparam int RESET_CYCLES   = 12;
  localparam int RANDOM_ITEMS   = 1700;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 16;
  localparam int TIMEOUT_CYCLES = 500000;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;   // start_time[31:0], job_number[47:32], now_time[79:48]
  logic [1:0]  s_tuser = '0;   // operation[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [87:0] m_tdata;        // wait_seconds[31:0], head_job[47:32],
                               // head_start[79:48], occupancy[84:80], zero pad
  logic [2:0]  m_tuser;        // status[2:0]
  int          fail_count;
  int          results_owed;
  int          hold_req = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  time_ordered_job_queue #(.DEPTH(QUEUE_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  time_ordered_job_queue_checker #(.DEPTH(QUEUE_DEPTH)) queue_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // Offer one operation beat and hold it until accepted
  task automatic send_job(input logic [1:0] op, input logic [TIME_W-1:0] st,
                          input logic [JOB_W-1:0] jb, input logic [TIME_W-1:0] nw);
    logic took;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {nw, jb, st};
    do begin
      @(negedge clk);
      took = s_tready;
      @(posedge clk);
    end while (!took);
  endtask

  // Receiver: random stall segments, plus a long hold-off on each request
  initial begin : result_sink
    int served;
    int seg_len;
    int mode;
    served = 0;
    wait (!rst);
    forever begin
      if (hold_req != served) begin
        served = hold_req;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        mode    = $urandom_range(0, 2);
        seg_len = $urandom_range(16, 160);
        for (int k = 0; k < seg_len && hold_req == served; k++) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 4) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [1:0]        op;
    logic [TIME_W-1:0] st;
    logic [TIME_W-1:0] nw;
    logic [TIME_W-1:0] base_time;
    logic [JOB_W-1:0]  jb;
    logic [TIME_W-1:0] recent_start [8];
    int n;
    int burst;
    int gap;
    int insert_pct;
    int phase_left;
    int pick;
    int rs_idx;

    foreach (recent_start[i]) recent_start[i] = '0;
    rs_idx     = 0;
    insert_pct = 50;
    phase_left = 0;
    base_time  = '0;
    n          = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty queue: remove, check and the unused code
    send_job(OP_REMOVE, '0, '0, '0);
    send_job(OP_CHECK, '0, '0, TIME_MAX);
    send_job(OP_UNUSED, TIME_MAX, '1, TIME_MAX);
    // Latest possible start: waiting at time zero, ready when equal
    send_job(OP_INSERT, TIME_MAX, 16'hFFFF, '0);
    send_job(OP_CHECK, '0, '0, '0);
    send_job(OP_CHECK, '0, '0, TIME_MAX);
    send_job(OP_INSERT, '0, '0, TIME_MAX);
    send_job(OP_CHECK, '1, '1, '0);
    // Fill up with ties and mixed times, then overflow
    for (int k = 0; k < QUEUE_DEPTH - 2; k++) begin
      if (k < 4)       st = 32'd100;
      else if (k == 4) st = 32'd50;
      else if (k == 5) st = 32'd200;
      else             st = $urandom();
      send_job(OP_INSERT, st, 16'(k + 1), '0);
    end
    send_job(OP_INSERT, 32'd100, 16'hABCD, '0);
    send_job(OP_UNUSED, '0, '0, '0);
    send_job(OP_REMOVE, '0, '0, '0);
    send_job(OP_REMOVE, '0, '0, '0);

    // Pause until every result is back
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);

    // Random phases; the receiver holds off while bursts keep coming
    hold_req <= hold_req + 1;
    while (n < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 24);
      for (int k = 0; k < burst && n < RANDOM_ITEMS; k++) begin
        if (phase_left == 0) begin
          phase_left = $urandom_range(40, 160);
          case ($urandom_range(0, 2))
            0:       insert_pct = 75;
            1:       insert_pct = 50;
            default: insert_pct = 25;
          endcase
          base_time = ($urandom_range(0, 3) == 0) ? TIME_MAX - 32'd40 : $urandom();
        end
        phase_left--;

        pick = $urandom_range(0, 99);
        if (pick < 3)                   op = OP_UNUSED;
        else if (pick < 3 + insert_pct) op = OP_INSERT;
        else if (pick[0])               op = OP_CHECK;
        else                            op = OP_REMOVE;

        // Start times cluster for ties, with some spread and extremes
        pick = $urandom_range(0, 99);
        if (pick < 40)      st = base_time + $urandom_range(0, 15);
        else if (pick < 70) st = recent_start[$urandom_range(0, 7)];
        else if (pick < 95) st = $urandom();
        else                st = pick[0] ? TIME_MAX : '0;

        // Current time lands around queued start times to split ready and wait
        pick = $urandom_range(0, 99);
        if (pick < 40)      nw = recent_start[$urandom_range(0, 7)] + $urandom_range(0, 2) - 1;
        else if (pick < 60) nw = base_time + $urandom_range(0, 15);
        else if (pick < 90) nw = $urandom();
        else                nw = pick[0] ? TIME_MAX : '0;

        jb = 16'($urandom());
        if (op == OP_INSERT) begin
          recent_start[rs_idx] = st;
          rs_idx = (rs_idx + 1) % 8;
        end
        send_job(op, st, jb, nw);
        n++;

        // Midway: drain completely, then another long hold-off
        if (n == RANDOM_ITEMS / 2) begin
          s_tvalid <= 1'b0;
          do @(posedge clk); while (results_owed != 0);
          hold_req <= hold_req + 1;
        end
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end

    // Wait out the last results, then drain for DRAIN_CYCLES to catch strays
    s_tvalid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
